### rtl/tlbw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbw_pkg
// Shared types and constants of the two-level write-back TLB.
// ---------------------------------------------------------------------------
package tlbw_pkg;

   localparam int L1_ENTRIES  = 16;
   localparam int L2_ENTRIES  = 64;
   localparam int OFFSET_BITS = 12;
   localparam int VADDR_BITS  = 32;
   localparam int VPN_BITS    = VADDR_BITS - OFFSET_BITS;
   localparam int PPN_BITS    = 20;
   localparam int STAMP_BITS  = 40;
   localparam int L1_IDX_BITS = $clog2(L1_ENTRIES);
   localparam int L2_IDX_BITS = $clog2(L2_ENTRIES);

   // request function codes
   localparam logic [1:0] FUNC_TRANSLATE = 2'd0;
   localparam logic [1:0] FUNC_INVAL     = 2'd1;
   localparam logic [1:0] FUNC_FILL      = 2'd2;

   // level_hit codes
   localparam logic [1:0] LVL_NONE = 2'd0;
   localparam logic [1:0] LVL_L1   = 2'd1;
   localparam logic [1:0] LVL_L2   = 2'd2;

   typedef enum logic [1:0] {
      OP_TRANSLATE,
      OP_INVAL,
      OP_FILL
   } op_type;

   typedef enum logic [2:0] {
      KIND_XLATE = 3'd0,
      KIND_WALK  = 3'd1,
      KIND_WB    = 3'd2,
      KIND_INVAL = 3'd3,
      KIND_STRAY = 3'd4
   } kind_type;

   typedef struct packed {
      op_type                  op;
      logic [VADDR_BITS-1:0]   vaddr;
      logic                    wr;
      logic [VPN_BITS-1:0]     page;
      logic [PPN_BITS-1:0]     ppn;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qstat_type;

   typedef struct packed {
      logic                  dirty;
      logic [STAMP_BITS-1:0] stamp;
      logic [VPN_BITS-1:0]   vpn;
      logic [PPN_BITS-1:0]   ppn;
   } entry_type;

   typedef struct packed {
      kind_type              kind;
      logic [VADDR_BITS-1:0] paddr;
      logic [VPN_BITS-1:0]   walk_vpn;
      logic [1:0]            level_hit;
      logic [1:0]            inval_mask;
      logic                  last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TR_L1,
      ST_TR_L2,
      ST_INS,
      ST_SPILL,
      ST_L1W,
      ST_INV_L1,
      ST_INV_L2,
      ST_FL_L2,
      ST_WB,
      ST_FL_L1,
      ST_EMIT
   } state_type;

endpackage

### rtl/tlbw_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbw_front
// Accepts requests, decodes the function and queues them for the back end.
// ---------------------------------------------------------------------------
module tlbw_front import tlbw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [VADDR_BITS-1:0] req_vaddr,
   input  logic                  req_is_write,
   input  logic [VPN_BITS-1:0]   req_page_number,
   input  logic [PPN_BITS-1:0]   req_fill_ppn,
   output qstat_type             q_stat,
   input  logic                  q_pop
);

   item_type   q_mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   dec;

   // decode the function; the unused code is taken and dropped
   always_comb begin
      dec.vaddr = req_vaddr;
      dec.wr    = req_is_write;
      dec.page  = req_page_number;
      dec.ppn   = req_fill_ppn;
      push      = req_valid && req_ready;
      case (req_func)
         FUNC_TRANSLATE: dec.op = OP_TRANSLATE;
         FUNC_INVAL:     dec.op = OP_INVAL;
         FUNC_FILL:      dec.op = OP_FILL;
         default: begin
            dec.op = OP_TRANSLATE;
            push   = 1'b0;
         end
      endcase
   end

   assign req_ready   = (cnt_ff != 2'd2);
   assign q_stat.valid = (cnt_ff != 2'd0);
   assign q_stat.item  = q_mem_ff[rp_ff];

   // advance queue pointers
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wp_ff] <= dec;
      end
   end

endmodule

### rtl/tlbw_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlbw_back
// Sequencer over both TLB levels: entry scans, refill, write-back, results.
// ---------------------------------------------------------------------------
module tlbw_back import tlbw_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qstat_type q_stat,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam logic [L2_IDX_BITS-1:0] L1_LAST = L2_IDX_BITS'(L1_ENTRIES - 1);
   localparam logic [L2_IDX_BITS-1:0] L2_LAST = L2_IDX_BITS'(L2_ENTRIES - 1);

   // entry stores
   entry_type l1_mem [L1_ENTRIES];
   entry_type l2_mem [L2_ENTRIES];
   entry_type l1_rd_ff, l2_rd_ff;
   logic [L1_ENTRIES-1:0] l1_valid_ff, l1_valid_in;
   logic [L2_ENTRIES-1:0] l2_valid_ff, l2_valid_in;

   logic                   l1_we, l2_we;
   logic [L1_IDX_BITS-1:0] l1_wa;
   logic [L2_IDX_BITS-1:0] l2_wa;
   entry_type              l1_wd, l2_wd;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [STAMP_BITS-1:0] now_ff, now_in;
   item_type cur_ff, cur_in;

   // scan engine
   logic                   lvl_ff, lvl_in;
   logic [VPN_BITS-1:0]    key_ff, key_in;
   logic                   iss_ff, iss_in;
   logic [L2_IDX_BITS-1:0] idx_ff, idx_in;
   logic                   rd_act_ff, rd_act_in;
   logic [L2_IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic                   found_ff, found_in;
   logic [L2_IDX_BITS-1:0] hit_idx_ff, hit_idx_in;
   entry_type              hit_ent_ff, hit_ent_in;
   logic                   vinv_ff, vinv_in;
   logic [L2_IDX_BITS-1:0] vic_idx_ff, vic_idx_in;
   entry_type              vic_ent_ff, vic_ent_in;
   logic                   vic_val_ff, vic_val_in;

   // saved L1 victim and install data
   logic [L1_IDX_BITS-1:0] l1v_idx_ff, l1v_idx_in;
   entry_type              l1v_ent_ff, l1v_ent_in;
   logic                   l1v_val_ff, l1v_val_in;
   logic [VPN_BITS-1:0]    ins_vpn_ff, ins_vpn_in;
   logic [PPN_BITS-1:0]    ins_ppn_ff, ins_ppn_in;
   logic                   ins_dirty_ff, ins_dirty_in;

   rsp_type    res_ff, res_in;
   logic [1:0] mask_ff, mask_in;

   logic                  pend_ff, pend_in;
   logic [VADDR_BITS-1:0] pend_va_ff, pend_va_in;
   logic                  pend_wr_ff, pend_wr_in;

   rsp_type out_ff, out_in;
   logic    out_vld_ff, out_vld_in;

   logic                start;
   logic                start_lvl;
   logic [VPN_BITS-1:0] start_key;
   state_type           start_ret;
   logic                out_free, out_load;
   rsp_type             out_res;
   entry_type           rd_ent;
   logic                rd_v;
   logic [L2_IDX_BITS-1:0] last_idx, spill_idx;
   logic [VPN_BITS-1:0] cur_vpn, pend_vpn;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
   assign last_idx  = lvl_ff ? L2_LAST : L1_LAST;
   assign rd_ent    = lvl_ff ? l2_rd_ff : l1_rd_ff;
   assign rd_v      = lvl_ff ? l2_valid_ff[rd_idx_ff]
                             : l1_valid_ff[rd_idx_ff[L1_IDX_BITS-1:0]];
   assign cur_vpn   = cur_ff.vaddr[VADDR_BITS-1:OFFSET_BITS];
   assign pend_vpn  = pend_va_ff[VADDR_BITS-1:OFFSET_BITS];
   assign spill_idx = found_ff ? hit_idx_ff : vic_idx_ff;

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      now_in       = now_ff;
      cur_in       = cur_ff;
      lvl_in       = lvl_ff;
      key_in       = key_ff;
      iss_in       = iss_ff;
      idx_in       = idx_ff;
      rd_act_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_ent_in   = hit_ent_ff;
      vinv_in      = vinv_ff;
      vic_idx_in   = vic_idx_ff;
      vic_ent_in   = vic_ent_ff;
      vic_val_in   = vic_val_ff;
      l1v_idx_in   = l1v_idx_ff;
      l1v_ent_in   = l1v_ent_ff;
      l1v_val_in   = l1v_val_ff;
      ins_vpn_in   = ins_vpn_ff;
      ins_ppn_in   = ins_ppn_ff;
      ins_dirty_in = ins_dirty_ff;
      res_in       = res_ff;
      mask_in      = mask_ff;
      pend_in      = pend_ff;
      pend_va_in   = pend_va_ff;
      pend_wr_in   = pend_wr_ff;
      l1_valid_in  = l1_valid_ff;
      l2_valid_in  = l2_valid_ff;
      l1_we        = 1'b0;
      l1_wa        = l1v_idx_ff;
      l1_wd        = l1v_ent_ff;
      l2_we        = 1'b0;
      l2_wa        = spill_idx;
      l2_wd        = l1v_ent_ff;
      q_pop        = 1'b0;
      start        = 1'b0;
      start_lvl    = 1'b0;
      start_key    = cur_vpn;
      start_ret    = ST_IDLE;
      out_load     = 1'b0;
      out_res      = res_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_stat.valid) begin
               q_pop  = 1'b1;
               now_in = now_ff + 1'b1;
               cur_in = q_stat.item;
               case (q_stat.item.op)
                  OP_TRANSLATE: begin
                     start     = 1'b1;
                     start_key = q_stat.item.vaddr[VADDR_BITS-1:OFFSET_BITS];
                     start_ret = ST_TR_L1;
                  end
                  OP_INVAL: begin
                     mask_in   = 2'b00;
                     start     = 1'b1;
                     start_key = q_stat.item.page;
                     start_ret = ST_INV_L1;
                  end
                  OP_FILL: begin
                     if (!pend_ff) begin
                        res_in      = '0;
                        res_in.kind = KIND_STRAY;
                        res_in.last = 1'b1;
                        state_in    = ST_EMIT;
                     end else begin
                        start     = 1'b1;
                        start_lvl = 1'b1;
                        start_key = pend_vpn;
                        start_ret = ST_FL_L2;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         // issue one read a cycle, evaluate the entry read the cycle before
         ST_SCAN: begin
            if (iss_ff) begin
               rd_act_in = 1'b1;
               rd_idx_in = idx_ff;
               if (idx_ff == last_idx) begin
                  iss_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (rd_act_ff) begin
               if (!found_ff && rd_v && rd_ent.vpn == key_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_ent_in = rd_ent;
               end
               if (!vinv_ff) begin
                  if (!rd_v) begin
                     vinv_in    = 1'b1;
                     vic_idx_in = rd_idx_ff;
                     vic_val_in = 1'b0;
                  end else if (rd_idx_ff == '0 || rd_ent.stamp < vic_ent_ff.stamp) begin
                     vic_idx_in = rd_idx_ff;
                     vic_ent_in = rd_ent;
                     vic_val_in = 1'b1;
                  end
               end
               if (rd_idx_ff == last_idx) begin
                  state_in = ret_ff;
               end
            end
         end

         ST_TR_L1: begin
            if (found_ff) begin
               l1_we       = 1'b1;
               l1_wa       = hit_idx_ff[L1_IDX_BITS-1:0];
               l1_wd       = hit_ent_ff;
               l1_wd.dirty = hit_ent_ff.dirty | cur_ff.wr;
               l1_wd.stamp = now_ff;
               res_in      = '0;
               res_in.kind = KIND_XLATE;
               res_in.paddr = {hit_ent_ff.ppn, cur_ff.vaddr[OFFSET_BITS-1:0]};
               res_in.level_hit = LVL_L1;
               res_in.last = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               l1v_idx_in = vic_idx_ff[L1_IDX_BITS-1:0];
               l1v_ent_in = vic_ent_ff;
               l1v_val_in = vic_val_ff;
               start      = 1'b1;
               start_lvl  = 1'b1;
               start_key  = cur_vpn;
               start_ret  = ST_TR_L2;
            end
         end

         ST_TR_L2: begin
            res_in = '0;
            res_in.last = 1'b1;
            if (found_ff) begin
               l2_we        = 1'b1;
               l2_wa        = hit_idx_ff;
               l2_wd        = hit_ent_ff;
               l2_wd.dirty  = hit_ent_ff.dirty | cur_ff.wr;
               l2_wd.stamp  = now_ff;
               ins_vpn_in   = cur_vpn;
               ins_ppn_in   = hit_ent_ff.ppn;
               ins_dirty_in = cur_ff.wr;
               res_in.kind  = KIND_XLATE;
               res_in.paddr = {hit_ent_ff.ppn, cur_ff.vaddr[OFFSET_BITS-1:0]};
               res_in.level_hit = LVL_L2;
               state_in     = ST_INS;
            end else begin
               pend_in         = 1'b1;
               pend_va_in      = cur_ff.vaddr;
               pend_wr_in      = cur_ff.wr;
               res_in.kind     = KIND_WALK;
               res_in.walk_vpn = cur_vpn;
               state_in        = ST_EMIT;
            end
         end

         // a dirty L1 victim goes back into L2 before the refill
         ST_INS: begin
            if (l1v_val_ff && l1v_ent_ff.dirty) begin
               start     = 1'b1;
               start_lvl = 1'b1;
               start_key = l1v_ent_ff.vpn;
               start_ret = ST_SPILL;
            end else begin
               state_in = ST_L1W;
            end
         end

         ST_SPILL: begin
            l2_we       = 1'b1;
            l2_wa       = spill_idx;
            l2_wd       = l1v_ent_ff;
            l2_wd.dirty = 1'b1;
            l2_wd.stamp = now_ff;
            l2_valid_in[spill_idx] = 1'b1;
            state_in    = ST_L1W;
         end

         ST_L1W: begin
            l1_we       = 1'b1;
            l1_wa       = l1v_idx_ff;
            l1_wd.dirty = ins_dirty_ff;
            l1_wd.stamp = now_ff;
            l1_wd.vpn   = ins_vpn_ff;
            l1_wd.ppn   = ins_ppn_ff;
            l1_valid_in[l1v_idx_ff] = 1'b1;
            state_in    = ST_EMIT;
         end

         ST_INV_L1: begin
            if (found_ff) begin
               l1_valid_in[hit_idx_ff[L1_IDX_BITS-1:0]] = 1'b0;
               mask_in[0] = 1'b1;
            end
            start     = 1'b1;
            start_lvl = 1'b1;
            start_key = cur_ff.page;
            start_ret = ST_INV_L2;
         end

         ST_INV_L2: begin
            res_in            = '0;
            res_in.kind       = KIND_INVAL;
            res_in.inval_mask = {found_ff, mask_ff[0]};
            res_in.last       = 1'b1;
            if (found_ff) begin
               l2_valid_in[hit_idx_ff] = 1'b0;
            end
            state_in = ST_EMIT;
         end

         // install the walked page in L2, report a dirty L2 victim
         ST_FL_L2: begin
            l2_we       = 1'b1;
            l2_wa       = vic_idx_ff;
            l2_wd.dirty = pend_wr_ff;
            l2_wd.stamp = now_ff;
            l2_wd.vpn   = pend_vpn;
            l2_wd.ppn   = cur_ff.ppn;
            l2_valid_in[vic_idx_ff] = 1'b1;
            if (vic_val_ff && vic_ent_ff.dirty) begin
               res_in       = '0;
               res_in.kind  = KIND_WB;
               res_in.paddr = {vic_ent_ff.ppn, {OFFSET_BITS{1'b0}}};
               state_in     = ST_WB;
            end else begin
               start     = 1'b1;
               start_ret = ST_FL_L1;
            end
         end

         ST_WB: begin
            if (out_free) begin
               out_load  = 1'b1;
               start     = 1'b1;
               start_ret = ST_FL_L1;
            end
         end

         ST_FL_L1: begin
            l1v_idx_in   = vic_idx_ff[L1_IDX_BITS-1:0];
            l1v_ent_in   = vic_ent_ff;
            l1v_val_in   = vic_val_ff;
            ins_vpn_in   = pend_vpn;
            ins_ppn_in   = cur_ff.ppn;
            ins_dirty_in = pend_wr_ff;
            res_in       = '0;
            res_in.kind  = KIND_XLATE;
            res_in.paddr = {cur_ff.ppn, pend_va_ff[OFFSET_BITS-1:0]};
            res_in.level_hit = LVL_NONE;
            res_in.last  = 1'b1;
            pend_in      = 1'b0;
            state_in     = ST_INS;
         end

         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // launch a scan of one level
      if (start) begin
         lvl_in   = start_lvl;
         key_in   = start_key;
         ret_in   = start_ret;
         iss_in   = 1'b1;
         idx_in   = '0;
         found_in = 1'b0;
         vinv_in  = 1'b0;
         state_in = ST_SCAN;
      end
   end

   // hold or drain the result register
   always_comb begin
      out_in     = out_load ? out_res : out_ff;
      out_vld_in = out_load ? 1'b1 : (out_vld_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ret_ff      <= ST_IDLE;
         now_ff      <= '0;
         iss_ff      <= 1'b0;
         rd_act_ff   <= 1'b0;
         pend_ff     <= 1'b0;
         pend_va_ff  <= '0;
         pend_wr_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
         l1_valid_ff <= '0;
         l2_valid_ff <= '0;
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         now_ff      <= now_in;
         iss_ff      <= iss_in;
         rd_act_ff   <= rd_act_in;
         pend_ff     <= pend_in;
         pend_va_ff  <= pend_va_in;
         pend_wr_ff  <= pend_wr_in;
         out_vld_ff  <= out_vld_in;
         l1_valid_ff <= l1_valid_in;
         l2_valid_ff <= l2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      lvl_ff       <= lvl_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      hit_ent_ff   <= hit_ent_in;
      vinv_ff      <= vinv_in;
      vic_idx_ff   <= vic_idx_in;
      vic_ent_ff   <= vic_ent_in;
      vic_val_ff   <= vic_val_in;
      l1v_idx_ff   <= l1v_idx_in;
      l1v_ent_ff   <= l1v_ent_in;
      l1v_val_ff   <= l1v_val_in;
      ins_vpn_ff   <= ins_vpn_in;
      ins_ppn_ff   <= ins_ppn_in;
      ins_dirty_ff <= ins_dirty_in;
      res_ff       <= res_in;
      mask_ff      <= mask_in;
      out_ff       <= out_in;
   end

   // entry memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (l1_we) begin
         l1_mem[l1_wa] <= l1_wd;
      end
      l1_rd_ff <= l1_mem[idx_ff[L1_IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (l2_we) begin
         l2_mem[l2_wa] <= l2_wd;
      end
      l2_rd_ff <= l2_mem[idx_ff];
   end

endmodule

### rtl/two_level_tlb_lru_writeback.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_level_tlb_lru_writeback
// Two-level fully associative TLB with LRU replacement and dirty write-back.
// ---------------------------------------------------------------------------
// Requests enter a two-deep queue and are carried out one at a time by a
// sequencer that scans the 16-entry L1 and the 64-entry L2 one entry per
// cycle through a registered memory read port. An L1 hit takes one L1
// scan; an L2 hit or miss adds an L2 scan, and a dirty L1 victim another
// L2 scan; a fill scans L2 and L1 and possibly L2 again. The unused
// function code is taken and dropped without a result.
module two_level_tlb_lru_writeback import tlbw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [VADDR_BITS-1:0] req_vaddr,
   input  logic                  req_is_write,
   input  logic [VPN_BITS-1:0]   req_page_number,
   input  logic [PPN_BITS-1:0]   req_fill_ppn,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_kind,
   output logic [VADDR_BITS-1:0] rsp_paddr,
   output logic [VPN_BITS-1:0]   rsp_walk_vpn,
   output logic [1:0]            rsp_level_hit,
   output logic [1:0]            rsp_inval_mask,
   output logic                  rsp_last
);

   qstat_type q_stat;
   logic      q_pop;
   rsp_type   rsp_data;

   tlbw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_vaddr       (req_vaddr),
      .req_is_write    (req_is_write),
      .req_page_number (req_page_number),
      .req_fill_ppn    (req_fill_ppn),
      .q_stat          (q_stat),
      .q_pop           (q_pop)
   );

   tlbw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // unpack the result
   assign rsp_kind       = rsp_data.kind;
   assign rsp_paddr      = rsp_data.paddr;
   assign rsp_walk_vpn   = rsp_data.walk_vpn;
   assign rsp_level_hit  = rsp_data.level_hit;
   assign rsp_inval_mask = rsp_data.inval_mask;
   assign rsp_last       = rsp_data.last;

   // a write-back report is always followed by the fill translation
   a_wb_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WB |-> !rsp_last)
      else $error("write-back result marked last");

   // only translations report a hit level
   a_level_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level_hit != LVL_NONE |-> rsp_kind == KIND_XLATE)
      else $error("hit level on a non-translation result");

   // the back end pops only a queued item
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.valid)
      else $error("pop from empty queue");

endmodule

### sim/two_level_tlb_lru_writeback_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_level_tlb_lru_writeback_test
// Self-checking bench for the two-level write-back TLB.
// ---------------------------------------------------------------------------
// A short table of directed requests (stray fill, empty invalidate, the
// ignored function code, address extremes, walk replacement) is followed by
// random translate / walk-fill sequences over a page pool larger than both
// levels, so that LRU eviction, dirty spills and L2 write-backs all occur.
// A behavioral copy of both levels predicts the responses that the table does
// not give; all are compared field by field in order while both sides idle at random.
// ---------------------------------------------------------------------------
module two_level_tlb_lru_writeback_test;
   import tlbw_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         RND_ITEMS   = 530;
   localparam int         POOL_SIZE   = 96;
   localparam int         HOLD_CYCLES = 600;
   localparam int         IDLE_LIMIT  = 4000;

   typedef struct {
      kind_type             kind;
      logic [31:0]          paddr;
      logic [VPN_BITS-1:0]  wvpn;
      logic [1:0]           lvl;
      logic [1:0]           mask;
      logic                 last;
   } tlb_rsp_type;

   typedef struct {
      bit                   valid;
      bit                   dirty;
      logic [STAMP_BITS-1:0] stamp;
      logic [VPN_BITS-1:0]  vpn;
      logic [PPN_BITS-1:0]  ppn;
   } tlb_line_type;

   typedef struct {
      logic [1:0]           func;
      logic [31:0]          va;
      bit                   wr;
      logic [VPN_BITS-1:0]  pn;
      logic [PPN_BITS-1:0]  ppn;
      bit                   typed;
      tlb_rsp_type          rsp;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func = '0;
   logic [VADDR_BITS-1:0] req_vaddr = '0;
   logic                  req_is_write = 1'b0;
   logic [VPN_BITS-1:0]   req_page_number = '0;
   logic [PPN_BITS-1:0]   req_fill_ppn = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_kind;
   logic [VADDR_BITS-1:0] rsp_paddr;
   logic [VPN_BITS-1:0]   rsp_walk_vpn;
   logic [1:0]            rsp_level_hit;
   logic [1:0]            rsp_inval_mask;
   logic                  rsp_last;

   // predictor state
   tlb_line_type          l1_model [L1_ENTRIES];
   tlb_line_type          l2_model [L2_ENTRIES];
   logic [STAMP_BITS-1:0] stamp_now = '0;
   bit                    walk_open = 1'b0;
   logic [31:0]           walk_va = '0;
   bit                    walk_wr = 1'b0;

   tlb_rsp_type           rsp_expected [$];
   logic [VPN_BITS-1:0]   page_pool [POOL_SIZE];
   dir_row_type           dir [0:11];

   int  mismatches = 0;
   int  items_sent = 0;
   int  rsps_seen  = 0;
   int  walks_seen = 0;
   int  wbacks_seen = 0;
   int  l2_hits_seen = 0;
   int  idle_cycles = 0;
   bit  stim_done = 1'b0;

   two_level_tlb_lru_writeback DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_vaddr(req_vaddr), .req_is_write(req_is_write),
      .req_page_number(req_page_number), .req_fill_ppn(req_fill_ppn),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_paddr(rsp_paddr), .rsp_walk_vpn(rsp_walk_vpn),
      .rsp_level_hit(rsp_level_hit), .rsp_inval_mask(rsp_inval_mask),
      .rsp_last(rsp_last)
   );

   always #6 clock = ~clock;

   // lookup and LRU victim selection, one pair per level
   function automatic int l1_find(logic [VPN_BITS-1:0] vpn);
      for (int i = 0; i < L1_ENTRIES; i++)
         if (l1_model[i].valid && l1_model[i].vpn == vpn) return i;
      return -1;
   endfunction

   function automatic int l2_find(logic [VPN_BITS-1:0] vpn);
      for (int i = 0; i < L2_ENTRIES; i++)
         if (l2_model[i].valid && l2_model[i].vpn == vpn) return i;
      return -1;
   endfunction

   function automatic int l1_victim();
      int best;
      logic [STAMP_BITS-1:0] lo;
      best = 0;
      lo = l1_model[0].stamp;
      for (int i = 0; i < L1_ENTRIES; i++) begin
         if (!l1_model[i].valid) return i;
         if (l1_model[i].stamp < lo) begin
            lo = l1_model[i].stamp;
            best = i;
         end
      end
      return best;
   endfunction

   function automatic int l2_victim();
      int best;
      logic [STAMP_BITS-1:0] lo;
      best = 0;
      lo = l2_model[0].stamp;
      for (int i = 0; i < L2_ENTRIES; i++) begin
         if (!l2_model[i].valid) return i;
         if (l2_model[i].stamp < lo) begin
            lo = l2_model[i].stamp;
            best = i;
         end
      end
      return best;
   endfunction

   // place a page in L1, spilling a dirty victim into L2
   task automatic l1_install(logic [VPN_BITS-1:0] vpn, logic [PPN_BITS-1:0] ppn,
                             bit dirty);
      int k;
      int j;
      tlb_line_type old;
      k = l1_victim();
      old = l1_model[k];
      if (old.valid && old.dirty) begin
         j = l2_find(old.vpn);
         if (j < 0) j = l2_victim();
         l2_model[j] = '{1'b1, 1'b1, stamp_now, old.vpn, old.ppn};
      end
      l1_model[k] = '{1'b1, dirty, stamp_now, vpn, ppn};
   endtask

   function automatic tlb_rsp_type mk_rsp(kind_type k, logic [31:0] pa,
                                          logic [VPN_BITS-1:0] wv, logic [1:0] lv,
                                          logic [1:0] m, logic l);
      tlb_rsp_type r;
      r.kind = k; r.paddr = pa; r.wvpn = wv; r.lvl = lv; r.mask = m; r.last = l;
      return r;
   endfunction

   // advance the model by one accepted request; queue its responses if asked
   task automatic tlb_apply(logic [1:0] func, logic [31:0] va, bit wr,
                            logic [VPN_BITS-1:0] pn, logic [PPN_BITS-1:0] fppn,
                            bit keep);
      logic [VPN_BITS-1:0] vpn;
      logic [PPN_BITS-1:0] ppn;
      logic [1:0] m;
      int i;
      tlb_rsp_type out [$];
      if (func == FUNC_UNUSED) return;
      stamp_now = stamp_now + 1'b1;
      vpn = va[31:OFFSET_BITS];
      if (func == FUNC_TRANSLATE) begin
         i = l1_find(vpn);
         if (i >= 0) begin
            l1_model[i].stamp = stamp_now;
            if (wr) l1_model[i].dirty = 1'b1;
            out.push_back(mk_rsp(KIND_XLATE, {l1_model[i].ppn, va[OFFSET_BITS-1:0]},
                                 '0, LVL_L1, 2'b00, 1'b1));
         end else begin
            i = l2_find(vpn);
            if (i >= 0) begin
               ppn = l2_model[i].ppn;
               l2_model[i].stamp = stamp_now;
               if (wr) l2_model[i].dirty = 1'b1;
               l1_install(vpn, ppn, wr);
               l2_hits_seen++;
               out.push_back(mk_rsp(KIND_XLATE, {ppn, va[OFFSET_BITS-1:0]},
                                    '0, LVL_L2, 2'b00, 1'b1));
            end else begin
               walk_open = 1'b1;
               walk_va = va;
               walk_wr = wr;
               walks_seen++;
               out.push_back(mk_rsp(KIND_WALK, '0, vpn, LVL_NONE, 2'b00, 1'b1));
            end
         end
      end else if (func == FUNC_INVAL) begin
         m = 2'b00;
         i = l1_find(pn);
         if (i >= 0) begin
            l1_model[i].valid = 1'b0;
            l1_model[i].dirty = 1'b0;
            m[0] = 1'b1;
         end
         i = l2_find(pn);
         if (i >= 0) begin
            l2_model[i].valid = 1'b0;
            l2_model[i].dirty = 1'b0;
            m[1] = 1'b1;
         end
         out.push_back(mk_rsp(KIND_INVAL, '0, '0, LVL_NONE, m, 1'b1));
      end else if (!walk_open) begin
         out.push_back(mk_rsp(KIND_STRAY, '0, '0, LVL_NONE, 2'b00, 1'b1));
      end else begin
         // fill: L2 first (maybe reporting a dirty victim), then L1
         vpn = walk_va[31:OFFSET_BITS];
         i = l2_victim();
         if (l2_model[i].valid && l2_model[i].dirty) begin
            wbacks_seen++;
            out.push_back(mk_rsp(KIND_WB, {l2_model[i].ppn, {OFFSET_BITS{1'b0}}},
                                 '0, LVL_NONE, 2'b00, 1'b0));
         end
         l2_model[i] = '{1'b1, walk_wr, stamp_now, vpn, fppn};
         l1_install(vpn, fppn, walk_wr);
         out.push_back(mk_rsp(KIND_XLATE, {fppn, walk_va[OFFSET_BITS-1:0]},
                              '0, LVL_NONE, 2'b00, 1'b1));
         walk_open = 1'b0;
      end
      if (keep)
         foreach (out[n]) rsp_expected.push_back(out[n]);
   endtask

   // offer one request and hold it until the transfer
   task automatic send_req(logic [1:0] func, logic [31:0] va, bit wr,
                           logic [VPN_BITS-1:0] pn, logic [PPN_BITS-1:0] fppn,
                           bit keep);
      req_valid <= 1'b1;
      req_func <= func;
      req_vaddr <= va;
      req_is_write <= wr;
      req_page_number <= pn;
      req_fill_ppn <= fppn;
      do @(posedge clock); while (!(req_valid && req_ready));
      tlb_apply(func, va, wr, pn, fppn, keep);
      items_sent++;
   endtask

   // sender: burst length and gap between bursts are both random
   int burst_left = 0;
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pool_va();
      logic [VPN_BITS-1:0] vpn;
      if ($urandom_range(0, 9) == 0) vpn = VPN_BITS'($urandom);
      else vpn = page_pool[$urandom_range(0, POOL_SIZE - 1)];
      return {vpn, OFFSET_BITS'($urandom)};
   endfunction

   // stimulus
   initial begin
      logic [1:0] f;
      int r;
      foreach (page_pool[i]) page_pool[i] = VPN_BITS'($urandom);
      page_pool[0] = '0;
      page_pool[1] = '1;
      dir[0]  = '{FUNC_FILL, 32'h0, 1'b0, 20'h0, 20'h12345, 1'b1,
                  mk_rsp(KIND_STRAY, '0, '0, LVL_NONE, 2'b00, 1'b1)};
      dir[1]  = '{FUNC_INVAL, 32'h0, 1'b0, 20'h0, 20'h0, 1'b1,
                  mk_rsp(KIND_INVAL, '0, '0, LVL_NONE, 2'b00, 1'b1)};
      dir[2]  = '{FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF, 20'hFFFFF, 1'b0,
                  mk_rsp(KIND_XLATE, '0, '0, LVL_NONE, 2'b00, 1'b0)};
      dir[3]  = '{FUNC_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 20'h0, 20'h0, 1'b1,
                  mk_rsp(KIND_WALK, '0, 20'hFFFFF, LVL_NONE, 2'b00, 1'b1)};
      dir[4]  = '{FUNC_FILL, 32'h0, 1'b0, 20'h0, 20'hFFFFF, 1'b1,
                  mk_rsp(KIND_XLATE, 32'hFFFF_FFFF, '0, LVL_NONE, 2'b00, 1'b1)};
      dir[5]  = '{FUNC_TRANSLATE, 32'hFFFF_F000, 1'b0, 20'h0, 20'h0, 1'b0,
                  mk_rsp(KIND_XLATE, '0, '0, LVL_NONE, 2'b00, 1'b0)};
      dir[6]  = '{FUNC_TRANSLATE, 32'h0, 1'b0, 20'h0, 20'h0, 1'b1,
                  mk_rsp(KIND_WALK, '0, '0, LVL_NONE, 2'b00, 1'b1)};
      dir[7]  = '{FUNC_TRANSLATE, 32'h0000_1234, 1'b1, 20'h0, 20'h0, 1'b1,
                  mk_rsp(KIND_WALK, '0, 20'h1, LVL_NONE, 2'b00, 1'b1)};
      dir[8]  = '{FUNC_FILL, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF, 20'h0, 1'b1,
                  mk_rsp(KIND_XLATE, 32'h234, '0, LVL_NONE, 2'b00, 1'b1)};
      dir[9]  = '{FUNC_TRANSLATE, 32'h0000_1FFF, 1'b0, 20'h0, 20'h0, 1'b0,
                  mk_rsp(KIND_XLATE, '0, '0, LVL_NONE, 2'b00, 1'b0)};
      dir[10] = '{FUNC_INVAL, 32'h0, 1'b0, 20'hFFFFF, 20'h0, 1'b1,
                  mk_rsp(KIND_INVAL, '0, '0, LVL_NONE, 2'b11, 1'b1)};
      dir[11] = '{FUNC_FILL, 32'h0, 1'b0, 20'h0, 20'h0, 1'b1,
                  mk_rsp(KIND_STRAY, '0, '0, LVL_NONE, 2'b00, 1'b1)};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table: typed rows queue their written-in answer
      foreach (dir[i]) begin
         send_req(dir[i].func, dir[i].va, dir[i].wr, dir[i].pn, dir[i].ppn,
                  !dir[i].typed);
         if (dir[i].typed && dir[i].func != FUNC_UNUSED)
            rsp_expected.push_back(dir[i].rsp);
         pace();
      end

      // random part: mostly translate followed by its walk fill
      for (int n = 0; n < RND_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         if (walk_open && r < 80) f = FUNC_FILL;
         else if (r < 80) f = FUNC_TRANSLATE;
         else if (r < 83) f = FUNC_FILL;
         else if (r < 93) f = FUNC_INVAL;
         else if (r < 95) f = FUNC_UNUSED;
         else f = FUNC_TRANSLATE;
         if (f == FUNC_INVAL && $urandom_range(0, 3) != 0)
            send_req(f, $urandom, 1'($urandom), VPN_BITS'(pool_va() >> OFFSET_BITS),
                     PPN_BITS'($urandom), 1'b1);
         else if (f == FUNC_TRANSLATE || r >= 80)
            send_req(f, pool_va(), 1'($urandom), VPN_BITS'($urandom),
                     PPN_BITS'($urandom), 1'b1);
         else
            send_req(f, $urandom, 1'($urandom), VPN_BITS'($urandom),
                     PPN_BITS'($urandom), 1'b1);
         pace();
      end
      req_valid <= 1'b0;

      // drain, then watch for stragglers
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      stim_done = 1'b1;
      $display("Sent %0d requests, checked %0d responses: %0d walks, %0d L2 hits,",
               items_sent, rsps_seen, walks_seen, l2_hits_seen);
      $display("%0d L2 write-backs, %0d mismatches.", wbacks_seen, mismatches);
      if (mismatches == 0 && rsp_expected.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // receiver: stall pattern, stretches of full rate, one long hold-off
   int  rx_cycle = 0;
   bit  held_off = 1'b0;
   int  hold_left = 0;
   always @(posedge clock) begin
      tlb_rsp_type e;
      bit bad;
      rx_cycle <= rx_cycle + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_seen <= rsps_seen + 1;
         if (rsp_expected.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
               $display("Unexpected response kind=%0d paddr=%h", rsp_kind, rsp_paddr);
         end else begin
            e = rsp_expected.pop_front();
            bad = (rsp_kind !== e.kind) || (rsp_paddr !== e.paddr) ||
                  (rsp_walk_vpn !== e.wvpn) || (rsp_level_hit !== e.lvl) ||
                  (rsp_inval_mask !== e.mask) || (rsp_last !== e.last);
            if (bad) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  $display("Mismatch: exp kind=%0d pa=%h vpn=%h lvl=%0d m=%0d last=%0d",
                           e.kind, e.paddr, e.wvpn, e.lvl, e.mask, e.last);
                  $display("          got kind=%0d pa=%h vpn=%h lvl=%0d m=%0d last=%0d",
                           rsp_kind, rsp_paddr, rsp_walk_vpn, rsp_level_hit,
                           rsp_inval_mask, rsp_last);
               end
            end
         end
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!held_off && rsps_seen == 60) begin
         held_off <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if ((rx_cycle / 256) % 3 == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= (rx_cycle % 5 != 0) && ($urandom_range(0, 3) != 0);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

endmodule
